// File: rtl/askf_pkg.sv
package askf_pkg;

	// Field and register widths
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned GAIN_BITS = 16;
	localparam int unsigned GAIN_W    = GAIN_BITS + 1;
	localparam int unsigned CFG_IDX_W = 3;

	// Divide-by-five unit: six times a 32-bit value, padded to whole 2-bit digits
	localparam int unsigned SCALE_W      = 36;
	localparam int unsigned SCALE_DIGITS = SCALE_W / 2;
	localparam int unsigned SCALE_CNT_W  = $clog2(SCALE_DIGITS + 1);

	// Register reset values
	localparam logic [DATA_W-1:0] RST_INIT_Q    = 32'd655;
	localparam logic [DATA_W-1:0] RST_INIT_R    = 32'd65536;
	localparam logic              RST_ADAPTIVE  = 1'b1;
	localparam logic [DATA_W-1:0] RST_THRESHOLD = 32'd655360;
	localparam logic [DATA_W-1:0] RST_Q_MIN     = 32'd66;
	localparam logic [DATA_W-1:0] RST_Q_MAX     = 32'd6554;
	localparam logic [DATA_W-1:0] RST_R_MIN     = 32'd32768;
	localparam logic [DATA_W-1:0] RST_R_MAX     = 32'd327680;

	localparam logic [DATA_W-1:0] COV_ONE  = DATA_W'(1) << FRAC_BITS;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INIT_Q    = 3'd0,
		CFG_INIT_R    = 3'd1,
		CFG_ADAPTIVE  = 3'd2,
		CFG_THRESHOLD = 3'd3,
		CFG_Q_MIN     = 3'd4,
		CFG_Q_MAX     = 3'd5,
		CFG_R_MIN     = 3'd6,
		CFG_R_MAX     = 3'd7
	} cfg_idx_t;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic signed [DATA_W-1:0] measurement;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] estimate;
		logic [GAIN_W-1:0]        gain;
		logic                     large_innovation;
		logic                     estimate_saturated;
	} result_t;

	// Sequencing of the serial units
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} unit_ctl_t;

endpackage

// File: rtl/askf_if.sv
interface askf_sample_if;
	import askf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface askf_result_if;
	import askf_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/adaptive_scalar_kalman_filter_core.sv
// Scalar Kalman filter for load-cell samples in Q16.16. A sample item passes from acceptance
// through prediction, the denominator, the bit-serial gain divider and then the two shift-add
// multipliers, which run together, to its result in the output register; the next item can be
// accepted in the cycle after that. A restart item skips the divider and the multipliers. The
// divider and the multipliers each need GAIN_BITS+1 steps. The divide-by-five units that retune
// Q and R run alongside them. Items are processed one at a time. A result waiting in the output
// register does not block the next item from being accepted, only its commit. Configuration
// writes take effect immediately and must only be issued while the filter is idle.
module adaptive_scalar_kalman_filter_core import askf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_wdata,
	askf_sample_if.sink          samples,
	askf_result_if.source        results
);

	localparam int unsigned CNT_W = $clog2(GAIN_BITS + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PRED = 7'b0000010,
		ST_DEN  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MLD  = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [DATA_W-1:0] init_q_q, init_r_q, thr_q, q_min_q, q_max_q, r_min_q, r_max_q;
	logic              adaptive_q;

	// Filter state
	logic signed [DATA_W-1:0] est_q;
	logic [DATA_W-1:0]        cov_q, q_noise_q, r_noise_q;

	// Per-item working registers
	logic                     kind_q;
	logic signed [DATA_W-1:0] meas_q;
	logic [DATA_W-1:0]        ppred_q;
	logic [DATA_W:0]          mag_q;
	logic                     neg_q;
	logic [DATA_W:0]          denom_q;
	logic                     large_q;
	logic [CNT_W-1:0]         cnt_q;

	logic    out_valid_q;
	result_t out_data_q;

	logic              out_free, cnt_last;
	logic [DATA_W:0]   ppred_sum, innov;
	logic [DATA_W-1:0] ppred;
	logic [GAIN_W-1:0] gain, gain_comp;
	logic [DATA_W+1:0] corr, est_ext, est_sum;
	logic [DATA_W:0]   cov_prod, q_scaled, r_scaled;
	logic              sat_hi, sat_lo;
	logic [DATA_W-1:0] est_new, q_new, r_new;
	unit_ctl_t         div_ctl, mul_ctl, scl_ctl;

	assign out_free = !out_valid_q || results.ready;
	assign cnt_last = (cnt_q == CNT_W'(GAIN_BITS));
	assign samples.ready = (state_q == ST_IDLE);

	// Prediction and innovation
	always_comb begin
		ppred_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
		ppred     = ppred_sum[DATA_W] ? '1 : ppred_sum[DATA_W-1:0];
		innov     = {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
	end

	// Sequence the serial units
	always_comb begin
		div_ctl.load = (state_q == ST_DEN);
		div_ctl.step = (state_q == ST_DIV);
		div_ctl.last = cnt_last;
		mul_ctl.load = (state_q == ST_MLD);
		mul_ctl.step = (state_q == ST_MUL);
		mul_ctl.last = cnt_last;
		scl_ctl.load = (state_q == ST_DIV) && (cnt_q == '0);
		scl_ctl.step = !scl_ctl.load &&
			((state_q == ST_DIV) || (state_q == ST_MLD) || (state_q == ST_MUL));
		scl_ctl.last = 1'b0;
	end

	askf_div u_div (
		.clk  (clk),
		.ctl  (div_ctl),
		.ppred(ppred_q),
		.denom(denom_q),
		.gain (gain)
	);

	assign gain_comp = GAIN_ONE - gain;

	askf_mul #(.A_W(DATA_W + 1), .B_W(GAIN_W)) u_mul_corr (
		.clk(clk),
		.ctl(mul_ctl),
		.a  (mag_q),
		.b  (gain),
		.p  (corr)
	);

	askf_mul #(.A_W(DATA_W), .B_W(GAIN_W)) u_mul_cov (
		.clk(clk),
		.ctl(mul_ctl),
		.a  (ppred_q),
		.b  (gain_comp),
		.p  (cov_prod)
	);

	askf_scale u_scale_q (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scl_ctl),
		.grow  (large_q),
		.value (q_noise_q),
		.result(q_scaled)
	);

	askf_scale u_scale_r (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scl_ctl),
		.grow  (!large_q),
		.value (r_noise_q),
		.result(r_scaled)
	);

	// Correct the estimate with saturation, clamp the retuned noise terms
	always_comb begin
		est_ext = {{2{est_q[DATA_W-1]}}, est_q};
		est_sum = neg_q ? est_ext - corr : est_ext + corr;
		sat_hi  = !est_sum[DATA_W+1] && (est_sum[DATA_W] || est_sum[DATA_W-1]);
		sat_lo  = est_sum[DATA_W+1] && !(est_sum[DATA_W] && est_sum[DATA_W-1]);
		if (sat_hi) begin
			est_new = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sat_lo) begin
			est_new = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			est_new = est_sum[DATA_W-1:0];
		end
		if (large_q) begin
			q_new = (q_scaled > {1'b0, q_max_q}) ? q_max_q : q_scaled[DATA_W-1:0];
			r_new = (r_scaled[DATA_W-1:0] < r_min_q) ? r_min_q : r_scaled[DATA_W-1:0];
		end else begin
			q_new = (q_scaled[DATA_W-1:0] < q_min_q) ? q_min_q : q_scaled[DATA_W-1:0];
			r_new = (r_scaled > {1'b0, r_max_q}) ? r_max_q : r_scaled[DATA_W-1:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q_q   <= RST_INIT_Q;
			init_r_q   <= RST_INIT_R;
			adaptive_q <= RST_ADAPTIVE;
			thr_q      <= RST_THRESHOLD;
			q_min_q    <= RST_Q_MIN;
			q_max_q    <= RST_Q_MAX;
			r_min_q    <= RST_R_MIN;
			r_max_q    <= RST_R_MAX;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_INIT_Q:    init_q_q   <= cfg_wdata;
				CFG_INIT_R:    init_r_q   <= cfg_wdata;
				CFG_ADAPTIVE:  adaptive_q <= cfg_wdata[0];
				CFG_THRESHOLD: thr_q      <= cfg_wdata;
				CFG_Q_MIN:     q_min_q    <= cfg_wdata;
				CFG_Q_MAX:     q_max_q    <= cfg_wdata;
				CFG_R_MIN:     r_min_q    <= cfg_wdata;
				CFG_R_MAX:     r_max_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Present a finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Control sequence and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			est_q       <= '0;
			cov_q       <= COV_ONE;
			q_noise_q   <= RST_INIT_Q;
			r_noise_q   <= RST_INIT_R;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						state_q <= ST_PRED;
					end
				end
				ST_PRED: begin
					state_q <= (kind_q == KIND_RESTART) ? ST_FIN : ST_DEN;
				end
				ST_DEN: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_MLD;
					end
				end
				ST_MLD: begin
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_RESTART) begin
							est_q     <= '0;
							cov_q     <= COV_ONE;
							q_noise_q <= init_q_q;
							r_noise_q <= init_r_q;
						end else begin
							est_q <= est_new;
							cov_q <= cov_prod[DATA_W-1:0];
							if (adaptive_q) begin
								q_noise_q <= q_new;
								r_noise_q <= r_new;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and working values
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			kind_q <= samples.data.kind;
			meas_q <= samples.data.measurement;
		end
		if (state_q == ST_PRED) begin
			ppred_q <= ppred;
			neg_q   <= innov[DATA_W];
			mag_q   <= innov[DATA_W] ? -innov : innov;
		end
		if (state_q == ST_DEN) begin
			denom_q <= {1'b0, ppred_q} + {1'b0, r_noise_q};
			large_q <= mag_q > {1'b0, thr_q};
		end
		if ((state_q == ST_FIN) && out_free) begin
			if (kind_q == KIND_RESTART) begin
				out_data_q <= '0;
			end else begin
				out_data_q.estimate           <= est_new;
				out_data_q.gain               <= gain;
				out_data_q.large_innovation   <= large_q;
				out_data_q.estimate_saturated <= sat_hi || sat_lo;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("item accepted while another is in flight");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_free |=> results.valid)
		else $error("finished item not presented");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.data.gain <= GAIN_ONE)
		else $error("gain above one");

	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_free && (kind_q == KIND_RESTART)
		|=> (results.data.estimate == '0) && (results.data.gain == '0))
		else $error("restart result not cleared");
`endif

endmodule

// File: rtl/askf_div.sv
module askf_div import askf_pkg::*; (
	input  logic              clk,
	input  unit_ctl_t         ctl,
	input  logic [DATA_W-1:0] ppred,
	input  logic [DATA_W:0]   denom,
	output logic [GAIN_W-1:0] gain
);

	logic [DATA_W+1:0] rem_q;
	logic [GAIN_W-1:0] quo_q;
	logic              take;
	logic [DATA_W+1:0] rem_left;

	// Restoring division, one quotient bit per step; a zero divisor yields zero
	always_comb begin
		take     = (denom != '0) && (rem_q >= {1'b0, denom});
		rem_left = take ? rem_q - {1'b0, denom} : rem_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= {2'b00, ppred};
			quo_q <= '0;
		end else if (ctl.step) begin
			rem_q <= {rem_left[DATA_W:0], 1'b0};
			quo_q <= {quo_q[GAIN_W-2:0], take};
		end
	end

	assign gain = quo_q;

endmodule

// File: rtl/askf_mul.sv
module askf_mul import askf_pkg::*; #(
	parameter int unsigned A_W = 32,
	parameter int unsigned B_W = 17
) (
	input  logic           clk,
	input  unit_ctl_t      ctl,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic [A_W:0]   p
);

	logic [A_W:0]   acc_q;
	logic [B_W-1:0] b_q;
	logic [A_W:0]   sum;

	// Shift-add from the low multiplier bit; the partial sum stays below 2*a
	assign sum = acc_q + (b_q[0] ? {1'b0, a} : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (ctl.step) begin
			acc_q <= ctl.last ? sum : (sum >> 1);
			b_q   <= b_q >> 1;
		end
	end

	// Product shifted right by B_W-1, truncated
	assign p = acc_q;

endmodule

// File: rtl/askf_scale.sv
module askf_scale import askf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  unit_ctl_t         ctl,
	input  logic              grow,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W:0]   result
);

	logic [SCALE_W-1:0]     num_q;
	logic [SCALE_W-1:0]     quo_q;
	logic [2:0]             rem_q;
	logic [SCALE_CNT_W-1:0] cnt_q;
	logic [4:0]             part;
	logic [1:0]             digit;
	logic [2:0]             rem_next;
	logic                   busy;

	// Long division by five, two numerator bits per step
	always_comb begin
		part = {rem_q, num_q[SCALE_W-1 -: 2]};
		if (part >= 5'd15) begin
			digit = 2'd3;
		end else if (part >= 5'd10) begin
			digit = 2'd2;
		end else if (part >= 5'd5) begin
			digit = 2'd1;
		end else begin
			digit = 2'd0;
		end
		rem_next = 3'(part - 5'(digit) * 5'd5);
	end

	assign busy = ctl.step && (cnt_q != '0);

	// Count digits still to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= SCALE_CNT_W'(SCALE_DIGITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load six or four times the value, then shift digits through
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= grow ? SCALE_W'({value, 2'b00}) + SCALE_W'({value, 1'b0})
			              : SCALE_W'({value, 2'b00});
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[SCALE_W-3:0], 2'b00};
			quo_q <= {quo_q[SCALE_W-3:0], digit};
			rem_q <= rem_next;
		end
	end

	assign result = quo_q[DATA_W:0];

endmodule

// File: verif/adaptive_scalar_kalman_filter_core_test.sv
module adaptive_scalar_kalman_filter_core_test;
	import askf_pkg::*;

	localparam int unsigned HALF_PERIOD = 6;
	localparam int unsigned RUN_LIMIT_CYCLES = 400000;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned HOLD_CYCLES = 300;

	// Register values after reset
	localparam logic [31:0] DEF_INIT_Q    = 32'd655;
	localparam logic [31:0] DEF_INIT_R    = 32'd65536;
	localparam logic        DEF_ADAPTIVE  = 1'b1;
	localparam logic [31:0] DEF_THRESHOLD = 32'd655360;
	localparam logic [31:0] DEF_Q_MIN     = 32'd66;
	localparam logic [31:0] DEF_Q_MAX     = 32'd6554;
	localparam logic [31:0] DEF_R_MIN     = 32'd32768;
	localparam logic [31:0] DEF_R_MAX     = 32'd327680;

	localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [31:0] MOST_POS  = 32'h7FFF_FFFF;
	localparam logic [31:0] MOST_NEG  = 32'h8000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_idx = CFG_INIT_Q;
	logic [31:0] cfg_wdata = '0;

	askf_sample_if smp();
	askf_result_if res();

	adaptive_scalar_kalman_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.samples   (smp),
		.results   (res)
	);

	// Filter copy: configuration
	logic [31:0] cfg_init_q;
	logic [31:0] cfg_init_r;
	logic        cfg_adaptive;
	logic [31:0] cfg_threshold;
	logic [31:0] cfg_q_min;
	logic [31:0] cfg_q_max;
	logic [31:0] cfg_r_min;
	logic [31:0] cfg_r_max;

	// Filter copy: running state
	logic signed [31:0] flt_est;
	logic [31:0]        flt_cov;
	logic [31:0]        flt_q;
	logic [31:0]        flt_r;

	sample_t pending_samples[$];
	result_t expected_results[$];

	int  n_accepted = 0;
	int  n_results = 0;
	int  n_errors = 0;
	int  tx_wait = 0;
	int  rx_wait = 0;
	bit  tx_idle = 1'b0;
	bit  rx_idle = 1'b0;
	logic hold_results = 1'b0;
	longint reading_base = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Reload the filter state from the initial noise registers
	function automatic void reload_filter();
		flt_est = '0;
		flt_cov = 32'd1 << FRAC_BITS;
		flt_q = cfg_init_q;
		flt_r = cfg_init_r;
	endfunction

	function automatic logic [31:0] noise_grow(logic [31:0] v, logic [31:0] hi);
		logic [63:0] t;
		t = (64'(v) * 64'd6) / 64'd5;
		return (t > 64'(hi)) ? hi : t[31:0];
	endfunction

	function automatic logic [31:0] noise_shrink(logic [31:0] v, logic [31:0] lo);
		logic [31:0] t;
		t = 32'((64'(v) * 64'd4) / 64'd5);
		return (t < lo) ? lo : t;
	endfunction

	// Advance the filter by one item and return the result it gives
	function automatic result_t kalman_step(sample_t s);
		result_t            r;
		logic [63:0]        ppred;
		logic [63:0]        denom;
		logic [63:0]        k;
		logic [63:0]        mag;
		logic [63:0]        corr;
		logic signed [63:0] est_wide;
		logic signed [63:0] innov;
		logic signed [63:0] x;
		logic               big_innov;
		r = '0;
		if (s.kind == KIND_RESTART) begin
			reload_filter();
			return r;
		end
		ppred = 64'(flt_cov) + 64'(flt_q);
		if (ppred > 64'(ALL_ONES))
			ppred = 64'(ALL_ONES);
		denom = ppred + 64'(flt_r);
		k = (denom == 64'd0) ? 64'd0 : (ppred << GAIN_BITS) / denom;

		est_wide = $signed({{32{flt_est[31]}}, flt_est});
		innov = $signed({{32{s.measurement[31]}}, s.measurement}) - est_wide;
		mag = innov[63] ? 64'(-innov) : 64'(innov);
		corr = (mag * k) >> GAIN_BITS;
		x = innov[63] ? est_wide - $signed(corr) : est_wide + $signed(corr);
		if (x > 64'sh7FFF_FFFF) begin
			x = 64'sh7FFF_FFFF;
			r.estimate_saturated = 1'b1;
		end
		if (x < -64'sh8000_0000) begin
			x = -64'sh8000_0000;
			r.estimate_saturated = 1'b1;
		end
		flt_est = x[31:0];
		flt_cov = 32'((ppred * ((64'd1 << GAIN_BITS) - k)) >> GAIN_BITS);

		// Retune the noise terms, when adaptation is on, by whether the innovation is above the threshold
		big_innov = mag > 64'(cfg_threshold);
		if (cfg_adaptive) begin
			if (big_innov) begin
				flt_q = noise_grow(flt_q, cfg_q_max);
				flt_r = noise_shrink(flt_r, cfg_r_min);
			end else begin
				flt_q = noise_shrink(flt_q, cfg_q_min);
				flt_r = noise_grow(flt_r, cfg_r_max);
			end
		end

		r.estimate = flt_est;
		r.gain = k[GAIN_W-1:0];
		r.large_innovation = big_innov;
		return r;
	endfunction

	// Write one register and keep the filter copy in step
	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_INIT_Q:    cfg_init_q = value;
			CFG_INIT_R:    cfg_init_r = value;
			CFG_ADAPTIVE:  cfg_adaptive = value[0];
			CFG_THRESHOLD: cfg_threshold = value;
			CFG_Q_MIN:     cfg_q_min = value;
			CFG_Q_MAX:     cfg_q_max = value;
			CFG_R_MIN:     cfg_r_min = value;
			CFG_R_MAX:     cfg_r_max = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_item(logic kind, logic [31:0] m);
		sample_t s;
		s.kind = kind;
		s.measurement = m;
		pending_samples.push_back(s);
	endfunction

	// Noise or threshold value spread over all magnitudes, extremes included
	function automatic logic [31:0] scaled_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return ALL_ONES;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// Load-cell style reading: a level with noise, steps and the odd wild value
	function automatic logic [31:0] next_reading();
		longint v;
		int     pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return $urandom;
		if (pick < 15)
			return pick[0] ? MOST_POS : MOST_NEG;
		if (pick < 23)
			reading_base = longint'($signed($urandom)) >>> $urandom_range(0, 24);
		v = reading_base + (longint'($signed($urandom)) >>> $urandom_range(4, 31));
		if (v > 64'sh7FFF_FFFF)
			v = 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			v = -64'sh8000_0000;
		return v[31:0];
	endfunction

	// Wait until every item has gone through and the filter is at rest
	task automatic wait_drained();
		while (pending_samples.size() != 0 || expected_results.size() != 0 || smp.valid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(cfg_idx_t lo_idx, cfg_idx_t hi_idx);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] t;
		lo = scaled_word();
		hi = scaled_word();
		// Keep the clamps ordered most of the time
		if ($urandom_range(0, 3) != 0 && lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		write_reg(lo_idx, lo);
		write_reg(hi_idx, hi);
	endtask

	// Sender: offer pending items, with a random gap drawn per item while tx_idle is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.data <= '0;
			tx_wait = 0;
		end else begin
			if (smp.valid && smp.ready) begin
				expected_results.push_back(kalman_step(smp.data));
				n_accepted++;
			end
			if (!smp.valid || smp.ready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					smp.valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					smp.data <= pending_samples.pop_front();
					smp.valid <= 1'b1;
					tx_wait = tx_idle ? $urandom_range(0, 4) : 0;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					n_errors++;
					if (n_errors <= REPORT_LIMIT)
						$display("result %0d arrived with nothing expected: est %h gain %h",
							n_results, res.data.estimate, res.data.gain);
				end else begin
					want = expected_results.pop_front();
					if (res.data.estimate !== want.estimate ||
							res.data.gain !== want.gain ||
							res.data.large_innovation !== want.large_innovation ||
							res.data.estimate_saturated !== want.estimate_saturated) begin
						n_errors++;
						if (n_errors <= REPORT_LIMIT)
							$display("result %0d: exp est %h gain %h large %b sat %b, %s%h %s%h %s%b %s%b",
								n_results, want.estimate, want.gain, want.large_innovation,
								want.estimate_saturated, "got est ", res.data.estimate,
								"gain ", res.data.gain, "large ", res.data.large_innovation,
								"sat ", res.data.estimate_saturated);
					end
				end
				n_results++;
				rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
			end
			if (hold_results) begin
				res.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Hold off the receiver for long stretches while items keep coming
	initial begin
		wait (n_accepted >= 120);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
		wait (n_accepted >= 560);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		#(HALF_PERIOD * 2 * RUN_LIMIT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int mode;
		smp.valid = 1'b0;
		smp.data = '0;
		res.ready = 1'b0;
		cfg_init_q = DEF_INIT_Q;
		cfg_init_r = DEF_INIT_R;
		cfg_adaptive = DEF_ADAPTIVE;
		cfg_threshold = DEF_THRESHOLD;
		cfg_q_min = DEF_Q_MIN;
		cfg_q_max = DEF_Q_MAX;
		cfg_r_min = DEF_R_MIN;
		cfg_r_max = DEF_R_MAX;
		reload_filter();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: innovation at the threshold and just above, both signs,
		// full-scale swings and a few quiet readings
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		@(negedge clk);
		add_item(KIND_RESTART, '0);
		add_item(KIND_SAMPLE, '0);
		add_item(KIND_SAMPLE, DEF_THRESHOLD);
		add_item(KIND_RESTART, ALL_ONES);
		add_item(KIND_SAMPLE, DEF_THRESHOLD + 32'd1);
		add_item(KIND_RESTART, '0);
		add_item(KIND_SAMPLE, -(DEF_THRESHOLD + 32'd1));
		add_item(KIND_RESTART, '0);
		add_item(KIND_SAMPLE, MOST_POS);
		add_item(KIND_SAMPLE, MOST_NEG);
		add_item(KIND_SAMPLE, MOST_POS);
		add_item(KIND_SAMPLE, MOST_NEG);
		add_item(KIND_SAMPLE, ALL_ONES);
		add_item(KIND_RESTART, '0);
		add_item(KIND_SAMPLE, 32'h0001_0000);
		add_item(KIND_SAMPLE, 32'h0001_0800);
		add_item(KIND_SAMPLE, 32'h0000_F800);
		wait_drained();

		// No noise at all: gain of one, then a zero denominator; adaptation off
		// with junk above the mode bit
		write_reg(CFG_INIT_Q, '0);
		write_reg(CFG_INIT_R, '0);
		write_reg(CFG_ADAPTIVE, 32'hFFFF_FFFE);
		write_reg(CFG_THRESHOLD, '0);
		@(negedge clk);
		add_item(KIND_RESTART, '0);
		add_item(KIND_SAMPLE, 32'h0005_0000);
		add_item(KIND_SAMPLE, 32'h0007_0000);
		add_item(KIND_SAMPLE, ALL_ONES);
		add_item(KIND_RESTART, '0);
		wait_drained();

		// Everything at full scale; Q clamps crossed, threshold never reached
		write_reg(CFG_INIT_Q, ALL_ONES);
		write_reg(CFG_INIT_R, ALL_ONES);
		write_reg(CFG_ADAPTIVE, 32'h0000_0001);
		write_reg(CFG_THRESHOLD, ALL_ONES);
		write_reg(CFG_Q_MIN, ALL_ONES);
		write_reg(CFG_Q_MAX, '0);
		write_reg(CFG_R_MIN, '0);
		write_reg(CFG_R_MAX, ALL_ONES);
		@(negedge clk);
		add_item(KIND_RESTART, '0);
		repeat (8) add_item(KIND_SAMPLE, next_reading());
		wait_drained();

		// Zero threshold: every step with a nonzero innovation grows Q past 32 bits and
		// shrinks R into a minimum that sits above its maximum
		write_reg(CFG_THRESHOLD, '0);
		write_reg(CFG_Q_MIN, '0);
		write_reg(CFG_Q_MAX, ALL_ONES);
		write_reg(CFG_R_MIN, ALL_ONES);
		write_reg(CFG_R_MAX, '0);
		@(negedge clk);
		add_item(KIND_RESTART, '0);
		repeat (8) add_item(KIND_SAMPLE, next_reading());
		wait_drained();

		// Random settings, each followed by a run of readings
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(CFG_INIT_Q, scaled_word());
			write_reg(CFG_INIT_R, scaled_word());
			write_reg(CFG_ADAPTIVE, ($urandom & ~32'd1) | 32'($urandom_range(0, 3) != 0));
			write_reg(CFG_THRESHOLD, scaled_word());
			write_limits(CFG_Q_MIN, CFG_Q_MAX);
			write_limits(CFG_R_MIN, CFG_R_MAX);
			mode = (phase == 0) ? 0 : $urandom_range(0, 3);
			tx_idle = mode[0];
			rx_idle = mode[1];
			@(negedge clk);
			add_item(KIND_RESTART, $urandom);
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(0, 99) < 4)
					add_item(KIND_RESTART, $urandom);
				else
					add_item(KIND_SAMPLE, next_reading());
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
